// ===== src/rtbd_pkg.sv =====
// Shared types, constants and tables for the radar track burst decoder.
package rtbd_pkg;

    localparam int WORD_W       = 16;
    localparam int KIND_W       = 3;
    localparam int REC_CNT_W    = 8;
    localparam int MAX_RECORDS_DEFAULT = 200;
    localparam int QUEUE_DEPTH  = 4;
    localparam int CORDIC_STEPS = 22;

    localparam logic [KIND_W-1:0] KIND_ACTIVE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CANCEL   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NO_TN    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BAD_HDR  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PLOT     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_END_OK   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_LEN_BAD  = 3'd6;

    localparam logic [WORD_W-1:0] HDR_START  = 16'hFFF4;
    localparam logic [WORD_W-1:0] HDR_CAT1   = 16'hE000;
    localparam logic [WORD_W-1:0] HDR_CAT2   = 16'h0642;
    localparam logic [WORD_W-1:0] HDR_PLOT   = 16'h046D;
    localparam logic [WORD_W-1:0] HDR_PRI1_A = 16'h8EC8;
    localparam logic [WORD_W-1:0] HDR_PRI1_B = 16'h8CC8;
    localparam logic [WORD_W-1:0] HDR_PRI2   = 16'h8640;

    localparam logic [5:0] SYM_CLUTTER = 6'o44;
    localparam logic [5:0] SYM_PRIMARY = 6'o46;

    // One unit of work handed from the parser to the record engine.
    typedef struct packed {
        logic              rec;
        logic              stat;
        logic [KIND_W-1:0] stat_kind;
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] w2;
        logic [WORD_W-1:0] w3;
        logic [WORD_W-1:0] w4;
        logic [WORD_W-1:0] w5;
        logic [WORD_W-1:0] w6;
        logic [WORD_W-1:0] w7;
    } job_t;

    // Arctangent of 2^-i in 1/2^24 turn.
    function automatic logic [21:0] atan_entry(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:    v = 22'd2097152;
            5'd1:    v = 22'd1238021;
            5'd2:    v = 22'd654136;
            5'd3:    v = 22'd332050;
            5'd4:    v = 22'd166669;
            5'd5:    v = 22'd83416;
            5'd6:    v = 22'd41718;
            5'd7:    v = 22'd20860;
            5'd8:    v = 22'd10430;
            5'd9:    v = 22'd5215;
            5'd10:   v = 22'd2608;
            5'd11:   v = 22'd1304;
            5'd12:   v = 22'd652;
            5'd13:   v = 22'd326;
            5'd14:   v = 22'd163;
            5'd15:   v = 22'd81;
            5'd16:   v = 22'd41;
            5'd17:   v = 22'd20;
            5'd18:   v = 22'd10;
            5'd19:   v = 22'd5;
            5'd20:   v = 22'd3;
            5'd21:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/radar_track_burst_decoder.sv =====
// Top level of the radar track burst decoder.
// Usage: words of a burst enter on data_word with end_of_message marking the
// last one, under in_valid and in_ready. Results leave on the output fields
// under out_valid and out_ready; run_end marks the last result of a word.
// A word is taken whenever the four-entry work queue has room, so input runs
// at one word per cycle until the queue fills. Header words and record words
// 0 to 6 give no work; a header error, the eighth word of a record or the
// final word of a burst that is not being discarded queue one item.
// A status-only item is taken and then goes straight to the result register.
// A record is taken, then the loop registers are loaded, the 22-step CORDIC
// heading loop runs, the result is rounded and the result register is loaded.
// The 15-digit square root and the X and Y scaling run beside the loop. A
// record that ends the burst then gives its end status after the record.
// The engine takes the next item only once it is back in idle, so it works on
// one record at a time, with the queue absorbing short runs.
// Reset returns the parser to waiting for a burst start word and empties the
// queue and output register. When the receiver stalls, the result register
// holds, the engine waits, the queue fills and in_ready drops.
module radar_track_burst_decoder #(
    parameter int MAX_RECORDS = rtbd_pkg::MAX_RECORDS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [rtbd_pkg::WORD_W-1:0] data_word,
    input  logic                        end_of_message,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rtbd_pkg::KIND_W-1:0] kind,
    output logic [9:0]                  track_number,
    output logic signed [20:0]          x_metres,
    output logic signed [20:0]          y_metres,
    output logic [14:0]                 speed_sixteenths,
    output logic [15:0]                 heading_turns,
    output logic [14:0]                 height_metres,
    output logic                        height_valid,
    output logic                        target_class,
    output logic                        clutter_warning,
    output logic                        run_end
);
    import rtbd_pkg::*;

    logic fire, push, pop, full, empty;
    job_t front_job, q_job;

    assign in_ready = !full;
    assign fire     = in_valid && in_ready;

    rtbd_front #(.MAX_RECORDS(MAX_RECORDS)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .data_word      (data_word),
        .end_of_message (end_of_message),
        .push           (push),
        .job            (front_job)
    );

    rtbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_job),
        .pop       (pop),
        .pop_data  (q_job),
        .full      (full),
        .empty     (empty)
    );

    rtbd_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (empty),
        .q_data           (q_job),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .track_number     (track_number),
        .x_metres         (x_metres),
        .y_metres         (y_metres),
        .speed_sixteenths (speed_sixteenths),
        .heading_turns    (heading_turns),
        .height_metres    (height_metres),
        .height_valid     (height_valid),
        .target_class     (target_class),
        .clutter_warning  (clutter_warning),
        .run_end          (run_end)
    );

endmodule

// ===== src/rtbd_front.sv =====
// Header checker and record splitter that turns words into work for the engine.
module rtbd_front #(
    parameter int MAX_RECORDS = rtbd_pkg::MAX_RECORDS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fire,
    input  logic [rtbd_pkg::WORD_W-1:0] data_word,
    input  logic                      end_of_message,
    output logic                      push,
    output rtbd_pkg::job_t            job
);
    import rtbd_pkg::*;

    localparam logic [2:0] PH_START   = 3'd0;
    localparam logic [2:0] PH_CAT1    = 3'd1;
    localparam logic [2:0] PH_CAT2    = 3'd2;
    localparam logic [2:0] PH_PRI1    = 3'd3;
    localparam logic [2:0] PH_PRI2    = 3'd4;
    localparam logic [2:0] PH_RECORDS = 3'd5;
    localparam logic [2:0] PH_DISCARD = 3'd6;

    localparam logic [REC_CNT_W-1:0] REC_LIMIT = REC_CNT_W'(MAX_RECORDS);

    logic [2:0]           phase_reg, phase_next;
    logic [2:0]           slot_reg, slot_next;
    logic [REC_CNT_W-1:0] recs_reg, recs_next;
    logic [WORD_W-1:0]    left_reg, left_next;
    logic [WORD_W-1:0]    words_reg [1:6];
    logic                 wr_en;

    always_comb
    begin
        phase_next    = phase_reg;
        slot_next     = slot_reg;
        recs_next     = recs_reg;
        left_next     = left_reg;
        wr_en         = 1'b0;
        job.rec       = 1'b0;
        job.stat      = 1'b0;
        job.stat_kind = KIND_BAD_HDR;
        job.w1        = words_reg[1];
        job.w2        = words_reg[2];
        job.w3        = words_reg[3];
        job.w4        = words_reg[4];
        job.w5        = words_reg[5];
        job.w6        = words_reg[6];
        job.w7        = data_word;

        case (phase_reg)
            PH_START:
            begin
                if (data_word == HDR_START)
                begin
                    phase_next = PH_CAT1;
                    slot_next  = 3'd0;
                    recs_next  = '0;
                    left_next  = '0;
                end
                else
                begin
                    job.stat   = 1'b1;
                    phase_next = PH_DISCARD;
                end
            end
            PH_CAT1:
            begin
                if (data_word == HDR_CAT1)
                    phase_next = PH_CAT2;
                else
                begin
                    job.stat   = 1'b1;
                    phase_next = PH_DISCARD;
                end
            end
            PH_CAT2:
            begin
                if (data_word == HDR_CAT2)
                    phase_next = PH_PRI1;
                else
                begin
                    job.stat      = 1'b1;
                    job.stat_kind = (data_word == HDR_PLOT) ? KIND_PLOT : KIND_BAD_HDR;
                    phase_next    = PH_DISCARD;
                end
            end
            PH_PRI1:
            begin
                if (data_word == HDR_PRI1_A || data_word == HDR_PRI1_B)
                    phase_next = PH_PRI2;
                else
                begin
                    job.stat   = 1'b1;
                    phase_next = PH_DISCARD;
                end
            end
            PH_PRI2:
            begin
                if (data_word == HDR_PRI2)
                begin
                    phase_next = PH_RECORDS;
                    slot_next  = 3'd0;
                end
                else
                begin
                    job.stat   = 1'b1;
                    phase_next = PH_DISCARD;
                end
            end
            PH_RECORDS:
            begin
                if (recs_reg >= REC_LIMIT)
                begin
                    if (left_reg != {WORD_W{1'b1}})
                        left_next = left_reg + 1'b1;
                end
                else if (slot_reg == 3'd7)
                begin
                    job.rec   = 1'b1;
                    slot_next = 3'd0;
                    recs_next = recs_reg + 1'b1;
                end
                else
                begin
                    wr_en     = 1'b1;
                    slot_next = slot_reg + 1'b1;
                end
            end
            PH_DISCARD:
            begin
                phase_next = PH_DISCARD;
            end
            default:
            begin
                phase_next = PH_DISCARD;
            end
        endcase

        if (end_of_message)
        begin
            if (phase_next inside {[PH_CAT1:PH_PRI2]})
            begin
                job.stat      = 1'b1;
                job.stat_kind = KIND_BAD_HDR;
            end
            else if (phase_next == PH_RECORDS)
            begin
                job.stat      = 1'b1;
                job.stat_kind = (left_next != '0 || slot_next != 3'd0 || recs_next == '0)
                              ? KIND_LEN_BAD : KIND_END_OK;
            end
            phase_next = PH_START;
            slot_next  = 3'd0;
        end
    end

    assign push = fire && (job.rec || job.stat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            slot_reg  <= 3'd0;
            recs_reg  <= '0;
            left_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            slot_reg  <= slot_next;
            recs_reg  <= recs_next;
            left_reg  <= left_next;
        end
    end

    // Word 0 of a record is never used, so only slots 1 to 6 are kept.
    always_ff @(posedge clk)
    begin
        if (fire && wr_en && slot_reg != 3'd0)
            words_reg[slot_reg] <= data_word;
    end

endmodule

// ===== src/rtbd_queue.sv =====
// Short work queue between the parser and the record engine.
module rtbd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rtbd_pkg::job_t push_data,
    input  logic           pop,
    output rtbd_pkg::job_t pop_data,
    output logic           full,
    output logic           empty
);
    import rtbd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [PTR_W:0]   count_reg;

    assign full     = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ===== src/rtbd_back.sv =====
// Record engine: scaling, CORDIC heading, square-root speed and the result register.
module rtbd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  rtbd_pkg::job_t              q_data,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rtbd_pkg::KIND_W-1:0] kind,
    output logic [9:0]                  track_number,
    output logic signed [20:0]          x_metres,
    output logic signed [20:0]          y_metres,
    output logic [14:0]                 speed_sixteenths,
    output logic [15:0]                 heading_turns,
    output logic [14:0]                 height_metres,
    output logic                        height_valid,
    output logic                        target_class,
    output logic                        clutter_warning,
    output logic                        run_end
);
    import rtbd_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SETUP   = 3'd1;
    localparam logic [2:0] S_RUN     = 3'd2;
    localparam logic [2:0] S_FIN     = 3'd3;
    localparam logic [2:0] S_OUT_REC = 3'd4;
    localparam logic [2:0] S_STAT    = 3'd5;

    localparam logic [4:0]  LAST_STEP = 5'(CORDIC_STEPS - 1);
    localparam logic [23:0] RECIP5    = 24'd13421773;

    logic [2:0]          state_reg;
    logic [4:0]          cnt_reg;
    job_t                job_reg;

    logic signed [31:0]  cx_reg, cy_reg;
    logic signed [25:0]  z_reg;
    logic [14:0]         sq_reg;
    logic [29:0]         rem_reg, root_reg, bit_reg;
    logic [26:0]         p_reg;
    logic [23:0]         mu_reg;
    logic [2:0]          r8_reg;
    logic [47:0]         prod_reg;
    logic signed [20:0]  x_reg, y_reg;
    logic [14:0]         speed_reg;
    logic [15:0]         hd_reg;
    logic                out_valid_reg;
    logic                out_free;

    // Sign-magnitude velocities and their magnitudes.
    logic signed [7:0]   xv, yv;
    logic [6:0]          ax, ay;
    assign ax = job_reg.w5[7:1];
    assign ay = job_reg.w4[7:1];
    assign xv = job_reg.w5[15] ? -$signed({1'b0, ax}) : $signed({1'b0, ax});
    assign yv = job_reg.w4[15] ? -$signed({1'b0, ay}) : $signed({1'b0, ay});

    assign out_free = !out_valid_reg || out_ready;
    assign pop      = (state_reg == S_IDLE) && !q_empty;
    assign out_valid = out_valid_reg;

    // Scaling by 28.575 is done on a biased positive value: divide by 8 by
    // shifting, then by 5 with a reciprocal multiply.
    logic [WORD_W-1:0]  scale_src;
    logic signed [27:0] scale_sum;
    assign scale_src = (cnt_reg == 5'd0) ? job_reg.w3 : job_reg.w2;
    assign scale_sum = 28'(signed'(scale_src)) * 28'sd1143 + 28'sd40000000;

    logic [21:0]        q5;
    logic [23:0]        r5_full;
    logic [5:0]         rmd;
    logic [21:0]        q_rnd;
    logic [21:0]        coord_full;
    assign q5      = prod_reg[47:26];
    assign r5_full = mu_reg - 24'(q5) * 24'd5;
    assign rmd     = {r5_full[2:0], r8_reg};
    assign q_rnd   = q5 + 22'((rmd > 6'd20 || (rmd == 6'd20 && q5[0])) ? 1 : 0);
    assign coord_full = q_rnd - 22'd1000000;

    // One CORDIC vectoring step.
    logic signed [31:0] dx, dy;
    logic signed [25:0] atan_v;
    assign dx     = cy_reg >>> cnt_reg;
    assign dy     = cx_reg >>> cnt_reg;
    assign atan_v = $signed({4'b0, atan_entry(cnt_reg)});

    // One digit of the square root.
    logic [29:0] trial;
    assign trial = root_reg + bit_reg;

    // Heading from the quadrant and the first-quadrant angle.
    logic [25:0] z_pos;
    logic [17:0] z_rnd;
    logic [16:0] quad;
    logic [16:0] angle;
    assign z_pos = z_reg[25] ? 26'd0 : z_reg;
    assign z_rnd = 18'((z_pos + 26'd128) >> 8);
    assign quad  = (z_rnd > 18'd16384) ? 17'd16384 : z_rnd[16:0];

    always_comb
    begin
        if (yv == 8'sd0)
            angle = (xv < 8'sd0) ? 17'd32768 : 17'd0;
        else if (xv == 8'sd0)
            angle = (yv > 8'sd0) ? 17'd16384 : 17'd49152;
        else if (xv > 8'sd0 && yv > 8'sd0)
            angle = quad;
        else if (xv < 8'sd0 && yv > 8'sd0)
            angle = 17'd32768 - quad;
        else if (xv < 8'sd0)
            angle = 17'd32768 + quad;
        else
            angle = 17'd65536 - quad;
    end

    // Record fields that come straight from the stored words.
    logic [4:0]  c1, c2, c3, c4, c5;
    logic        tn_ok, h_ok, active, rec_full;
    logic [9:0]  tn;
    logic [6:0]  hn;
    logic [35:0] h_prod;
    logic [5:0]  sym;
    assign c3     = job_reg.w6[15:11];
    assign c4     = job_reg.w6[10:6];
    assign c5     = job_reg.w6[5:1];
    assign c1     = job_reg.w7[15:11];
    assign c2     = job_reg.w7[10:6];
    assign tn_ok  = c3 < 5'd10 && c4 < 5'd10 && c5 < 5'd10;
    assign h_ok   = c1 < 5'd10 && c2 < 5'd10;
    assign tn     = 10'(c3) * 10'd100 + 10'(c4) * 10'd10 + 10'(c5);
    assign hn     = 7'(c1) * 7'd10 + 7'(c2);
    assign h_prod = 36'(hn) * 36'd319607184 + 36'd419432;
    assign sym    = job_reg.w1[7:2];
    assign active = job_reg.w1[15];
    // Only an active record with a valid track number carries the full set of fields.
    assign rec_full = active && tn_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_OUT_REC || state_reg == S_STAT) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                        state_reg <= q_data.rec ? S_SETUP : S_STAT;
                end
                S_SETUP:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST_STEP)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    state_reg <= S_OUT_REC;
                end
                S_OUT_REC:
                begin
                    if (out_free)
                        state_reg <= job_reg.stat ? S_STAT : S_IDLE;
                end
                S_STAT:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= q_data;

        if (state_reg == S_SETUP)
        begin
            cx_reg <= $signed({25'b0, ax}) <<< 20;
            cy_reg <= $signed({25'b0, ay}) <<< 20;
            z_reg  <= '0;
            sq_reg <= 15'(ax) * 15'(ax) + 15'(ay) * 15'(ay);
        end

        if (state_reg == S_RUN)
        begin
            if (cy_reg > 32'sd0)
            begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                z_reg  <= z_reg + atan_v;
            end
            else
            begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                z_reg  <= z_reg - atan_v;
            end

            if (cnt_reg == 5'd0)
            begin
                rem_reg  <= 30'(sq_reg) * 30'd10816;
                root_reg <= '0;
                bit_reg  <= 30'd1 << 28;
            end
            else if (cnt_reg <= 5'd15)
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg  <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                    root_reg <= root_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end

            // X enters at the first step and Y at the second.
            p_reg    <= scale_sum[26:0];
            mu_reg   <= p_reg[26:3];
            r8_reg   <= p_reg[2:0];
            prod_reg <= 48'(p_reg[26:3]) * 48'(RECIP5);
            if (cnt_reg == 5'd2)
                x_reg <= coord_full[20:0];
            if (cnt_reg == 5'd3)
                y_reg <= coord_full[20:0];
        end

        if (state_reg == S_FIN)
        begin
            speed_reg <= root_reg[14:0] + 15'((rem_reg > root_reg) ? 1 : 0);
            hd_reg    <= 16'd16384 - angle[15:0];
        end

        if (state_reg == S_OUT_REC && out_free)
        begin
            kind             <= active ? (tn_ok ? KIND_ACTIVE : KIND_NO_TN) : KIND_CANCEL;
            track_number     <= tn_ok ? tn : 10'd0;
            x_metres         <= rec_full ? x_reg : 21'sd0;
            y_metres         <= rec_full ? y_reg : 21'sd0;
            speed_sixteenths <= rec_full ? speed_reg : 15'd0;
            heading_turns    <= rec_full ? hd_reg : 16'd0;
            height_metres    <= (rec_full && h_ok) ? h_prod[34:20] : 15'd0;
            height_valid     <= rec_full && h_ok;
            target_class     <= rec_full && (sym == SYM_CLUTTER || sym == SYM_PRIMARY);
            clutter_warning  <= rec_full && (sym == SYM_CLUTTER);
            run_end          <= !job_reg.stat;
        end
        else if (state_reg == S_STAT && out_free)
        begin
            kind             <= job_reg.stat_kind;
            track_number     <= '0;
            x_metres         <= '0;
            y_metres         <= '0;
            speed_sixteenths <= '0;
            heading_turns    <= '0;
            height_metres    <= '0;
            height_valid     <= 1'b0;
            target_class     <= 1'b0;
            clutter_warning  <= 1'b0;
            run_end          <= 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_stat_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STAT) |-> job_reg.stat)
        else $error("status result without a status in the item");
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (cnt_reg <= LAST_STEP))
        else $error("iteration count out of range");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("result dropped before it was taken");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the radar track burst decoder.
module tb;
    import rtbd_pkg::*;

    localparam int MAXREC   = MAX_RECORDS_DEFAULT;
    localparam int WDOG_MAX = 20000;

    typedef enum logic [2:0] {
        ST_START, ST_CAT1, ST_CAT2, ST_PRI1, ST_PRI2, ST_RECORDS, ST_DISCARD
    } phase_t;

    typedef struct packed {
        logic [15:0] word;
        logic        eom;
    } word_item_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [9:0]         tn;
        logic signed [20:0] x;
        logic signed [20:0] y;
        logic [14:0]        sp;
        logic [15:0]        hd;
        logic [14:0]        h;
        logic               hv;
        logic               tc;
        logic               cw;
        logic               last;
    } report_t;

    logic clk, rst_n;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    logic in_ready, out_valid;
    logic [15:0] data_word = '0;
    logic end_of_message = 1'b0;
    logic [2:0] kind;
    logic [9:0] track_number;
    logic signed [20:0] x_metres, y_metres;
    logic [14:0] speed_sixteenths, height_metres;
    logic [15:0] heading_turns;
    logic height_valid, target_class, clutter_warning, run_end;

    radar_track_burst_decoder DUT (.*);

    word_item_t pending_words[$];
    report_t    expected_reports[$];
    int errors, words_sent, reports_seen, wdog;
    int hold_off;
    bit stall_done;

    // Predictor state.
    phase_t      ph = ST_START;
    int          slot = 0;
    int          recs = 0;
    int          leftover = 0;
    logic [15:0] rw[7];

    always begin
        clk = 1'b1; #10;
        clk = 1'b0; #10;
    end

    function automatic longint fshift(longint v, int s);
        if (v >= 0) return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint scale_pos(logic [15:0] w);
        longint v, p, q, r;
        v = $signed(w);
        p = v * 1143 + 40000000;
        q = p / 40;
        r = p % 40;
        if (r > 20 || (r == 20 && q[0])) q++;
        return q - 1000000;
    endfunction

    function automatic longint vel(logic [15:0] w);
        longint m;
        m = w[7:1];
        return w[15] ? -m : m;
    endfunction

    function automatic int quad(longint x, longint y);
        longint cx, cy, z, dx, dy, tab[22];
        tab = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
                10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};
        cx = x * 1048576; cy = y * 1048576; z = 0;
        for (int i = 0; i < 22; i++) begin
            dx = fshift(cy, i);
            dy = fshift(cx, i);
            if (cy > 0) begin cx += dx; cy -= dy; z += tab[i]; end
            else begin cx -= dx; cy += dy; z -= tab[i]; end
        end
        if (z < 0) z = 0;
        z = (z + 128) >>> 8;
        if (z > 16384) z = 16384;
        return int'(z);
    endfunction

    function automatic int bearing(longint x, longint y);
        if (y == 0) return (x < 0) ? 32768 : 0;
        if (x == 0) return (y > 0) ? 16384 : 49152;
        if (x > 0 && y > 0) return quad(x, y);
        if (x < 0 && y > 0) return 32768 - quad(-x, y);
        if (x < 0) return 32768 + quad(-x, -y);
        return 65536 - quad(x, -y);
    endfunction

    function automatic report_t status_report(logic [2:0] k);
        report_t r;
        r = '0;
        r.kind = k;
        return r;
    endfunction

    function automatic report_t decode_record(logic [15:0] last);
        report_t r;
        logic [5:0] sym;
        int c3, c4, c5, c1, c2, tn, p, hh;
        longint xv, yv, t, k;
        r = '0;
        sym = rw[1][7:2];
        c3 = rw[6][15:11]; c4 = rw[6][10:6]; c5 = rw[6][5:1];
        tn = (c3 < 10 && c4 < 10 && c5 < 10) ? c3 * 100 + c4 * 10 + c5 : -1;
        if (!rw[1][15]) begin
            r.kind = KIND_CANCEL;
            r.tn = (tn < 0) ? 10'd0 : 10'(tn);
            return r;
        end
        if (tn < 0) begin
            r.kind = KIND_NO_TN;
            return r;
        end
        r.kind = KIND_ACTIVE;
        r.tn = 10'(tn);
        c1 = last[15:11]; c2 = last[10:6];
        if (c1 < 10 && c2 < 10) begin
            p = (c1 * 10 + c2) * 1524;
            hh = p / 5;
            if (p % 5 >= 3) hh++;
            r.h = 15'(hh);
            r.hv = 1'b1;
        end
        yv = vel(rw[4]);
        xv = vel(rw[5]);
        t = 10816 * (xv * xv + yv * yv);
        k = longint'($floor($sqrt(real'(t))));
        while (k * k > t) k--;
        while ((k + 1) * (k + 1) <= t) k++;
        if (t > k * k + k) k++;
        r.sp = 15'(k);
        r.hd = 16'((16384 + 65536 - bearing(xv, yv)) & 16'hFFFF);
        r.x = 21'(scale_pos(rw[3]));
        r.y = 21'(scale_pos(rw[2]));
        r.tc = (sym == SYM_CLUTTER || sym == SYM_PRIMARY);
        r.cw = (sym == SYM_CLUTTER);
        return r;
    endfunction

    task automatic predict_word(word_item_t it);
        report_t outs[$];
        logic [15:0] w;
        w = it.word;
        case (ph)
            ST_START:
                if (w == HDR_START) begin
                    ph = ST_CAT1; slot = 0; recs = 0; leftover = 0;
                end else begin
                    outs.insert(outs.size(), status_report(KIND_BAD_HDR)); ph = ST_DISCARD;
                end
            ST_CAT1:
                if (w == HDR_CAT1) ph = ST_CAT2;
                else begin
                    outs.insert(outs.size(), status_report(KIND_BAD_HDR)); ph = ST_DISCARD;
                end
            ST_CAT2:
                if (w == HDR_CAT2) ph = ST_PRI1;
                else begin
                    outs.insert(outs.size(),
                                status_report(w == HDR_PLOT ? KIND_PLOT : KIND_BAD_HDR));
                    ph = ST_DISCARD;
                end
            ST_PRI1:
                if (w == HDR_PRI1_A || w == HDR_PRI1_B) ph = ST_PRI2;
                else begin
                    outs.insert(outs.size(), status_report(KIND_BAD_HDR)); ph = ST_DISCARD;
                end
            ST_PRI2:
                if (w == HDR_PRI2) begin ph = ST_RECORDS; slot = 0; end
                else begin
                    outs.insert(outs.size(), status_report(KIND_BAD_HDR)); ph = ST_DISCARD;
                end
            ST_RECORDS:
                if (recs >= MAXREC) begin
                    if (leftover < 65535) leftover++;
                end else if (slot >= 7) begin
                    outs.insert(outs.size(), decode_record(w)); slot = 0; recs++;
                end else begin
                    rw[slot] = w; slot++;
                end
            default: ph = ST_DISCARD;
        endcase
        if (it.eom) begin
            if (ph inside {ST_CAT1, ST_CAT2, ST_PRI1, ST_PRI2})
                outs.insert(outs.size(), status_report(KIND_BAD_HDR));
            else if (ph == ST_RECORDS)
                outs.insert(outs.size(),
                            status_report((leftover != 0 || slot != 0 || recs == 0)
                                          ? KIND_LEN_BAD : KIND_END_OK));
            ph = ST_START; slot = 0;
        end
        if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
        foreach (outs[i]) expected_reports.insert(expected_reports.size(), outs[i]);
    endtask

    // Stimulus builders.
    task automatic add(logic [15:0] w, logic e = 1'b0);
        word_item_t it;
        it.word = w; it.eom = e;
        pending_words.insert(pending_words.size(), it);
    endtask

    task automatic add_header(logic alt = 1'b0);
        add(HDR_START); add(HDR_CAT1); add(HDR_CAT2);
        add(alt ? HDR_PRI1_B : HDR_PRI1_A); add(HDR_PRI2);
    endtask

    function automatic logic [15:0] digits(int a, int b, int c);
        return {5'(a), 5'(b), 5'(c), 1'b0};
    endfunction

    // Record with mostly valid digits and random content; last gets eom.
    task automatic add_record(logic e);
        logic [15:0] w1, w6, w7;
        w1 = 16'($urandom);
        if ($urandom_range(0, 2) == 0) w1[7:2] = ($urandom_range(0, 1)) ? SYM_CLUTTER : SYM_PRIMARY;
        if ($urandom_range(0, 3) != 0) w1[15] = 1'b1;
        w6 = ($urandom_range(0, 5) == 0) ? 16'($urandom) :
             digits($urandom_range(0, 9), $urandom_range(0, 9), $urandom_range(0, 9)) |
             16'($urandom_range(0, 1));
        w7 = ($urandom_range(0, 5) == 0) ? 16'($urandom) :
             {digits($urandom_range(0, 9), $urandom_range(0, 9), 0)} | 16'($urandom_range(0, 63));
        add(16'($urandom)); add(w1); add(16'($urandom)); add(16'($urandom));
        add(16'($urandom)); add(16'($urandom)); add(w6); add(w7, e);
    endtask

    // Acceptance flag seen at the rising edge, used by the driver afterwards.
    logic in_ready_q;

    // Driver.
    int in_gap;
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap <= $urandom_range(0, 16);
        end else if (!in_valid || in_ready_q) begin
            // previous item accepted or none pending
            if (in_gap > 0 && pending_words.size() > 0) begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end else if (pending_words.size() > 0) begin
                word_item_t it;
                it = pending_words.pop_front();
                data_word <= it.word;
                end_of_message <= it.eom;
                in_valid <= 1'b1;
                in_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        in_ready_q <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready) begin
            word_item_t it;
            it.word = data_word; it.eom = end_of_message;
            predict_word(it);
            words_sent++;
        end
    end

    // Receiver. Once the first bursts are under way it holds off for a long
    // stretch so that the work queue fills and the input stalls.
    int out_gap;
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_gap <= 0;
            hold_off <= 0;
            stall_done <= 1'b0;
        end else if (!stall_done && words_sent >= 40) begin
            out_ready <= 1'b0;
            hold_off <= 600;
            stall_done <= 1'b1;
        end else if (hold_off > 0) begin
            out_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (out_gap > 0) begin
            out_ready <= 1'b0;
            out_gap <= out_gap - 1;
        end else begin
            out_ready <= 1'b1;
            if (out_valid && out_ready)
                out_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
        end
    end

    // Monitor.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            report_t e;
            reports_seen++;
            if (expected_reports.size() == 0) begin
                $error("unexpected result kind %0d", kind);
                errors++;
            end else begin
                e = expected_reports.pop_front();
                if (kind !== e.kind) begin $error("kind exp %0d got %0d", e.kind, kind); errors++; end
                if (track_number !== e.tn) begin
                    $error("track_number exp %0d got %0d", e.tn, track_number); errors++; end
                if (x_metres !== e.x) begin $error("x_metres exp %0d got %0d", e.x, x_metres); errors++; end
                if (y_metres !== e.y) begin $error("y_metres exp %0d got %0d", e.y, y_metres); errors++; end
                if (speed_sixteenths !== e.sp) begin
                    $error("speed_sixteenths exp %0d got %0d", e.sp, speed_sixteenths); errors++; end
                if (heading_turns !== e.hd) begin
                    $error("heading_turns exp %0d got %0d", e.hd, heading_turns); errors++; end
                if (height_metres !== e.h) begin
                    $error("height_metres exp %0d got %0d", e.h, height_metres); errors++; end
                if (height_valid !== e.hv) begin
                    $error("height_valid exp %0d got %0d", e.hv, height_valid); errors++; end
                if (target_class !== e.tc) begin
                    $error("target_class exp %0d got %0d", e.tc, target_class); errors++; end
                if (clutter_warning !== e.cw) begin
                    $error("clutter_warning exp %0d got %0d", e.cw, clutter_warning); errors++; end
                if (run_end !== e.last) begin
                    $error("run_end exp %0d got %0d", e.last, run_end); errors++; end
            end
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n || hold_off > 0)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        int nrec, kind_pick;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Directed: bad start, plot message, header cut short, bad header word, empty burst, extremes, partial record.
        add(16'h0000); add(16'hFFFF, 1'b1);
        add(HDR_START); add(HDR_CAT1); add(HDR_PLOT, 1'b1);
        add(HDR_START); add(HDR_CAT1, 1'b1);
        add(HDR_START); add(HDR_CAT1); add(HDR_CAT2); add(16'h0000, 1'b1);
        add_header(1'b1); add(16'h0000, 1'b1);            // no record
        add_header();
        add(16'h0000); add(16'h8000 | {SYM_CLUTTER, 2'b0}); add(16'h8000); add(16'h7FFF);
        add(16'h80FE); add(16'h00FE); add(digits(9, 9, 9)); add(digits(9, 9, 0), 1'b1);
        add_header(1'b1);
        add(16'h0000); add(16'hFFFF); add(16'h0000); add(16'hFFFF); add(16'h0000);
        add(16'h0000); add(16'hFFFF); add(16'hFFFF); add(16'h1234, 1'b1);  // partial record
        // The receiver stalls while this header and its records pile in.
        add_header();
        repeat (6) add_record(1'b0);
        add_record(1'b1);

        // Random bursts, mostly well formed.
        while (words_sent + pending_words.size() < 600) begin
            kind_pick = $urandom_range(0, 9);
            if (kind_pick == 0) begin
                add(16'($urandom), 1'($urandom_range(0, 1)));
            end else if (kind_pick == 1) begin
                add(HDR_START); add(HDR_CAT1);
                add($urandom_range(0, 1) ? HDR_PLOT : 16'($urandom));
                add(16'($urandom)); add(16'($urandom), 1'b1);
            end else begin
                add_header(1'($urandom_range(0, 1)));
                nrec = $urandom_range(1, 5);
                for (int i = 1; i < nrec; i++) add_record(1'b0);
                if (kind_pick == 2) begin
                    add_record(1'b0); add(16'($urandom), 1'b1);
                end else add_record(1'b1);
            end
        end

        wait (pending_words.size() == 0 && !in_valid);
        wait (expected_reports.size() == 0);
        repeat (100) @(posedge clk);
        $display("tb: drove %0d words through good, broken, plot and truncated bursts,",
                 words_sent);
        $display("tb: and checked %0d results under random stalls on both sides.",
                 reports_seen);
        if (errors == 0 && expected_reports.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
src/rtbd_pkg.sv
src/rtbd_front.sv
src/rtbd_queue.sv
src/rtbd_back.sv
src/radar_track_burst_decoder.sv
verif/tb.sv
